// File: rtl/rotation_matrix_to_quaternion_core_macros.svh
// Assertion macros for the rotation matrix to quaternion core.
// No dependencies; included by the top level for its property checks.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rmq check failed");
`define RMQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmq check failed");
`else
`define RMQ_ASSERT(name, expr)
`define RMQ_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// File: rtl/rmq_pkg.sv
// Shared constants and pipeline stage types for the quaternion core.
// No dependencies; used by the cells and the top level.
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int S_W       = 18;
  localparam int D_W       = 17;
  localparam int RAD_W     = 32;
  localparam int ROOT_W    = 16;
  localparam int REM_W     = 20;
  localparam int W_W       = 15;
  localparam int DEN_W     = 17;
  localparam int NUM_W     = 31;
  localparam int CMP_W     = 32;
  localparam int Q_W       = 15;
  localparam int FLOOR_W   = 15;
  localparam int SQ_STEPS  = 16;
  localparam int DIV_STEPS = 15;
  localparam int LANES     = 3;
  localparam logic [W_W-1:0]     OUT_LIM     = 15'd16384;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 15'd16;

  typedef struct packed {
    logic                    valid;
    logic                    below_floor;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic signed [D_W-1:0]   dz;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic [RAD_W-1:0]        rad;
  } sq_stage_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             sat;
  } dv_lane_t;

  typedef struct packed {
    logic                   valid;
    logic                   degen;
    logic [W_W-1:0]         wout;
    logic [DEN_W-1:0]       den;
    dv_lane_t [LANES-1:0]   lane;
  } dv_stage_t;
endpackage

// File: rtl/rmq_sqrt_cell.sv
// One digit step of the integer square root chain.
// Depends on rmq_pkg for the stage type.
`timescale 1ns / 1ps
module rmq_sqrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  rmq_pkg::sq_stage_t stage_in,
  output rmq_pkg::sq_stage_t stage_out
);
  localparam int PAD = rmq_pkg::REM_W - rmq_pkg::ROOT_W - 2;

  rmq_pkg::sq_stage_t         stage_r;
  rmq_pkg::sq_stage_t         stage_nxt;
  logic [rmq_pkg::REM_W-1:0]  rem_try;
  logic [rmq_pkg::REM_W-1:0]  trial;
  logic                       fits;

  always_comb begin
    // bring down the next two radicand bits, try root*4+1
    rem_try = {stage_in.rem[rmq_pkg::REM_W-3:0], stage_in.rad[rmq_pkg::RAD_W-1 -: 2]};
    trial   = {{PAD{1'b0}}, stage_in.root, 2'b01};
    fits    = (rem_try >= trial);
    stage_nxt      = stage_in;
    stage_nxt.rad  = {stage_in.rad[rmq_pkg::RAD_W-3:0], 2'b00};
    stage_nxt.rem  = fits ? (rem_try - trial) : rem_try;
    stage_nxt.root = {stage_in.root[rmq_pkg::ROOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;
endmodule

// File: rtl/rmq_div_cell.sv
// One quotient bit of the three-lane restoring divider chain.
// Depends on rmq_pkg for the stage type.
`timescale 1ns / 1ps
module rmq_div_cell #(
  parameter int BIT_POS = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  rmq_pkg::dv_stage_t stage_in,
  output rmq_pkg::dv_stage_t stage_out
);
  rmq_pkg::dv_stage_t        stage_r;
  rmq_pkg::dv_stage_t        stage_nxt;
  logic [rmq_pkg::CMP_W-1:0] den_sh;
  logic [rmq_pkg::CMP_W-1:0] rem_ext;
  logic                      fits;

  always_comb begin
    stage_nxt = stage_in;
    den_sh    = rmq_pkg::CMP_W'(stage_in.den) << BIT_POS;
    rem_ext   = '0;
    fits      = 1'b0;
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      rem_ext = rmq_pkg::CMP_W'(stage_in.lane[i].rem);
      fits    = (rem_ext >= den_sh);
      if (fits) begin
        stage_nxt.lane[i].rem = stage_in.lane[i].rem - den_sh[rmq_pkg::NUM_W-1:0];
      end
      stage_nxt.lane[i].q[BIT_POS] = fits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_out = stage_r;
endmodule

// File: rtl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion: top level, front/back stages and cell chains.
// Depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell and the macros header.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------
//   in      | input     | in_valid/in_ready  | in_m00 .. in_m22, Q1.14 signed
//   out     | output    | out_valid/out_ready| out_quat_w/x/y/z, out_degenerate
//   cfg     | input     | cfg_we             | cfg_wdata = trace floor, unsigned Q1.14
//
// One item enters per cycle, unless a held result stalls the chain, through 34 register
// stages: one front stage, 16 square root cells, one scaling stage, 15 divider cells
// and the output register.
// The sqrt digit chain and the divider bit chain set the depth.
// rst_n is synchronous; it clears all stage valid bits and loads the floor to 16.
// A stalled result freezes the whole chain; in_ready follows that advance enable.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m00,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m01,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m02,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m10,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m11,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m12,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m20,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m21,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_m22,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rmq_pkg::W_W-1:0]           out_quat_w,
  output logic signed [rmq_pkg::IN_W-1:0]   out_quat_x,
  output logic signed [rmq_pkg::IN_W-1:0]   out_quat_y,
  output logic signed [rmq_pkg::IN_W-1:0]   out_quat_z,
  output logic                              out_degenerate,
  input  logic                              cfg_we,
  input  logic [rmq_pkg::FLOOR_W-1:0]       cfg_wdata
);
`include "rotation_matrix_to_quaternion_core_macros.svh"

  localparam int FB = rmq_pkg::FRAC_BITS;

  logic                              adv;
  logic [rmq_pkg::FLOOR_W-1:0]       floor_r;

  // front stage signals
  logic signed [rmq_pkg::S_W-1:0]    s_sum;
  logic                              below;
  logic [rmq_pkg::S_W-2:0]           s_pos;
  rmq_pkg::sq_stage_t                head_nxt;
  rmq_pkg::sq_stage_t                head_r;
  rmq_pkg::sq_stage_t                sq_chain [rmq_pkg::SQ_STEPS+1];

  // scaling stage signals
  rmq_pkg::sq_stage_t                sq_last;
  logic [rmq_pkg::ROOT_W:0]          r_inc;
  logic [rmq_pkg::W_W-1:0]           w_val;
  logic signed [rmq_pkg::D_W-1:0]    dsel [rmq_pkg::LANES];
  logic [rmq_pkg::D_W-1:0]           mag;
  logic [rmq_pkg::NUM_W-1:0]         num;
  rmq_pkg::dv_stage_t                scale_nxt;
  rmq_pkg::dv_stage_t                scale_r;
  rmq_pkg::dv_stage_t                dv_chain [rmq_pkg::DIV_STEPS+1];

  // output stage signals
  rmq_pkg::dv_stage_t                dv_last;
  logic [rmq_pkg::Q_W-1:0]           q_sat;
  logic [rmq_pkg::IN_W-1:0]          q_ext;
  logic [rmq_pkg::IN_W-1:0]          vec_nxt [rmq_pkg::LANES];
  logic                              out_valid_r;
  logic [rmq_pkg::W_W-1:0]           quat_w_r;
  logic [rmq_pkg::IN_W-1:0]          vec_r [rmq_pkg::LANES];
  logic                              degen_r;

  // advance the whole chain unless a finished result is held
  assign adv      = ~out_valid_r | out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= rmq_pkg::FLOOR_RESET;
    end else if (cfg_we) begin
      floor_r <= cfg_wdata;
    end
  end

  // front: one plus trace, floor test, radicand and the off-diagonal differences
  always_comb begin
    s_sum = rmq_pkg::S_W'(in_m00) + rmq_pkg::S_W'(in_m11) + rmq_pkg::S_W'(in_m22)
          + rmq_pkg::S_W'(1 << FB);
    below = (s_sum < $signed({3'b000, floor_r}));
    s_pos = (s_sum > 0) ? s_sum[rmq_pkg::S_W-2:0] : '0;
    head_nxt             = '0;
    head_nxt.valid       = in_valid;
    head_nxt.below_floor = below;
    head_nxt.rad         = {1'b0, s_pos, {FB{1'b0}}};
    head_nxt.dx          = rmq_pkg::D_W'(in_m21) - rmq_pkg::D_W'(in_m12);
    head_nxt.dy          = rmq_pkg::D_W'(in_m02) - rmq_pkg::D_W'(in_m20);
    head_nxt.dz          = rmq_pkg::D_W'(in_m10) - rmq_pkg::D_W'(in_m01);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (adv) begin
      head_r <= head_nxt;
    end
  end

  assign sq_chain[0] = head_r;

  for (genvar g = 0; g < rmq_pkg::SQ_STEPS; g++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .stage_in  (sq_chain[g]),
      .stage_out (sq_chain[g+1])
    );
  end

  assign sq_last = sq_chain[rmq_pkg::SQ_STEPS];

  // scale: round root to w, form 4w and the rounded numerators, flag overflow early
  always_comb begin
    r_inc  = {1'b0, sq_last.root} + (rmq_pkg::ROOT_W+1)'(1);
    w_val  = r_inc[rmq_pkg::W_W:1];
    dsel[0] = sq_last.dx;
    dsel[1] = sq_last.dy;
    dsel[2] = sq_last.dz;
    mag = '0;
    num = '0;
    scale_nxt       = '0;
    scale_nxt.valid = sq_last.valid;
    scale_nxt.degen = sq_last.below_floor | (w_val == '0);
    scale_nxt.wout  = (w_val > rmq_pkg::OUT_LIM) ? rmq_pkg::OUT_LIM : w_val;
    scale_nxt.den   = {w_val, 2'b00};
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      mag = dsel[i][rmq_pkg::D_W-1] ? (-dsel[i]) : dsel[i];
      num = {mag, {FB{1'b0}}} + rmq_pkg::NUM_W'({w_val, 1'b0});
      scale_nxt.lane[i].rem = num;
      scale_nxt.lane[i].q   = '0;
      scale_nxt.lane[i].neg = dsel[i][rmq_pkg::D_W-1];
      scale_nxt.lane[i].sat = ({1'b0, num} >= {w_val, 2'b00, {rmq_pkg::Q_W{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r.valid <= 1'b0;
    end else if (adv) begin
      scale_r <= scale_nxt;
    end
  end

  assign dv_chain[0] = scale_r;

  // cell g resolves quotient bit (DIV_STEPS-1-g), most significant first
  for (genvar g = 0; g < rmq_pkg::DIV_STEPS; g++) begin : g_div
    rmq_div_cell #(
      .BIT_POS (rmq_pkg::DIV_STEPS - 1 - g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .stage_in  (dv_chain[g]),
      .stage_out (dv_chain[g+1])
    );
  end

  assign dv_last = dv_chain[rmq_pkg::DIV_STEPS];

  // back: saturate, restore sign, drop vector parts of a degenerate item
  always_comb begin
    q_sat = '0;
    q_ext = '0;
    for (int i = 0; i < rmq_pkg::LANES; i++) begin
      q_sat = (dv_last.lane[i].sat || (dv_last.lane[i].q > rmq_pkg::OUT_LIM))
            ? rmq_pkg::OUT_LIM : dv_last.lane[i].q;
      q_ext = {1'b0, q_sat};
      if (dv_last.degen) begin
        vec_nxt[i] = '0;
      end else begin
        vec_nxt[i] = dv_last.lane[i].neg ? (-q_ext) : q_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_last.valid;
    end
    if (adv) begin
      quat_w_r <= dv_last.wout;
      degen_r  <= dv_last.degen;
      for (int i = 0; i < rmq_pkg::LANES; i++) vec_r[i] <= vec_nxt[i];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_quat_w     = quat_w_r;
  assign out_quat_x     = vec_r[0];
  assign out_quat_y     = vec_r[1];
  assign out_quat_z     = vec_r[2];
  assign out_degenerate = degen_r;

  `RMQ_ASSERT(a_degen_zero, !(out_valid && out_degenerate) || (out_quat_x == 0 && out_quat_y == 0 && out_quat_z == 0))
  `RMQ_ASSERT(a_w_limit, !out_valid || (out_quat_w <= rmq_pkg::OUT_LIM))
  `RMQ_ASSERT(a_x_limit, !out_valid || (out_quat_x <= 16384 && out_quat_x >= -16384))
  `RMQ_ASSERT(a_stall_cause, in_ready || out_valid)
  `RMQ_ASSERT_NEXT(a_stall_freeze, out_valid && !out_ready, $stable(dv_last) && $stable(head_r))
endmodule

// File: test/tb.sv
// Self-checking bench for rotation_matrix_to_quaternion_core: directed and random matrices.
// Depends on rmq_pkg and the core; predicts each quaternion in integer arithmetic.
`timescale 1ns / 1ps
module tb;
  localparam int  DRAIN   = 40;      // a little over the pipeline depth
  localparam int  LIMIT   = 400000;
  localparam int  LONGOFF = 300;     // long receiver hold-off, in cycles

  typedef struct packed {
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    logic [14:0]        w;
    logic signed [15:0] x, y, z;
    logic               degen;
  } quat_t;

  logic                clk, rst_n;
  logic                in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0]  in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22;
  logic [14:0]         out_quat_w;
  logic signed [15:0]  out_quat_x, out_quat_y, out_quat_z;
  logic                out_degenerate;
  logic                cfg_we;
  logic [14:0]         cfg_wdata;

  matrix_t  matrix_q[$];       // items waiting to be offered
  quat_t    quat_q[$];         // predicted quaternions, oldest first
  matrix_t  cur;
  logic [14:0] floor_cfg;      // bench copy of the trace floor register
  logic     calm;              // no idling on either side
  logic     hold_req;          // ask the receiver for one long hold-off
  int       errors, n_in, n_out, n_degen, n_sat, cycles;

  rotation_matrix_to_quaternion_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_m00(in_m00), .in_m01(in_m01), .in_m02(in_m02),
    .in_m10(in_m10), .in_m11(in_m11), .in_m12(in_m12),
    .in_m20(in_m20), .in_m21(in_m21), .in_m22(in_m22),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x), .out_quat_y(out_quat_y),
    .out_quat_z(out_quat_z), .out_degenerate(out_degenerate),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-serial integer square root, floor result.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Off-diagonal difference over 4w, rounded half away from zero, saturated.
  function automatic logic [15:0] vector_part(longint d, longint unsigned w);
    longint unsigned mag, q;
    mag = (d < 0) ? -d : d;
    q = ((mag << rmq_pkg::FRAC_BITS) + (2 * w)) / (4 * w);
    if (q > rmq_pkg::OUT_LIM) q = rmq_pkg::OUT_LIM;
    return (d < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic quat_t predict_quat(matrix_t m, logic [14:0] flr);
    quat_t q;
    longint s;
    longint unsigned r, w;
    s = (longint'(1) << rmq_pkg::FRAC_BITS) + m.m00 + m.m11 + m.m22;
    r = int_sqrt((s > 0 ? s : 0) << rmq_pkg::FRAC_BITS);
    w = (r + 1) >> 1;
    q.w = (w > rmq_pkg::OUT_LIM) ? rmq_pkg::OUT_LIM : 15'(w);
    q.degen = (s < longint'(flr)) || (w == 0);
    if (q.degen) begin
      q.x = '0; q.y = '0; q.z = '0;
    end else begin
      q.x = vector_part(longint'(m.m21) - m.m12, w);
      q.y = vector_part(longint'(m.m02) - m.m20, w);
      q.z = vector_part(longint'(m.m10) - m.m01, w);
    end
    return q;
  endfunction

  // Driver: offer queued items, idle in random bursts between them.
  int gap;
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        quat_q.push_back(predict_quat(cur, floor_cfg));
        n_in++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap > 0) gap--;
        else if (matrix_q.size() > 0) begin
          cur = matrix_q.pop_front();
          nv = 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
        end
      end
      in_valid <= nv;
      {in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22} <= cur;
    end
  end

  // Monitor: check each result against the oldest prediction, stall at random.
  int stall, long_cnt;
  logic long_done;
  always @(posedge clk) begin
    quat_t e, a;
    logic nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall = 0;
      long_cnt = 0;
      long_done = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        a = '{out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_degenerate};
        n_out++;
        if (quat_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d degen=%0b",
                   $time, a.w, a.x, a.y, a.z, a.degen);
        end else begin
          e = quat_q.pop_front();
          if (e.degen) n_degen++;
          if (e.w == rmq_pkg::OUT_LIM || e.x == rmq_pkg::OUT_LIM || e.x == -rmq_pkg::OUT_LIM)
            n_sat++;
          if (a.w !== e.w) begin
            errors++;
            $display("%0t: quat_w expected %0d actual %0d", $time, e.w, a.w);
          end
          if (a.x !== e.x) begin
            errors++;
            $display("%0t: quat_x expected %0d actual %0d", $time, e.x, a.x);
          end
          if (a.y !== e.y) begin
            errors++;
            $display("%0t: quat_y expected %0d actual %0d", $time, e.y, a.y);
          end
          if (a.z !== e.z) begin
            errors++;
            $display("%0t: quat_z expected %0d actual %0d", $time, e.z, a.z);
          end
          if (a.degen !== e.degen) begin
            errors++;
            $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, a.degen);
          end
        end
      end
      // Hold off once for a long stretch so the pipeline fills and stalls its input.
      if (hold_req && !long_done) begin
        long_done = 1'b1;
        long_cnt = LONGOFF;
      end
      if (long_cnt > 0) begin
        long_cnt--;
        nr = 1'b0;
      end else if (stall > 0) begin
        stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 13);
      end
      out_ready <= nr;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic signed [15:0] to_fix(real v);
    return 16'($rtoi(v * 16384.0 + (v < 0 ? -0.5 : 0.5)));
  endfunction

  // Random unit quaternion turned into a rotation matrix; w is shrunk at random,
  // so traces near minus one (degenerate) show up too.
  function automatic matrix_t rotation_matrix();
    real a, b, c, d, n;
    matrix_t m;
    a = $itor($urandom_range(0, 2000)) - 1000.0;
    b = $itor($urandom_range(0, 2000)) - 1000.0;
    c = $itor($urandom_range(0, 2000)) - 1000.0;
    d = $itor($urandom_range(0, 2000)) - 1000.0;
    if ($urandom_range(0, 7) == 0) a = a / 64.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0; n = 1.0;
    end
    a /= n; b /= n; c /= n; d /= n;
    m.m00 = to_fix(1 - 2 * (c * c + d * d));
    m.m01 = to_fix(2 * (b * c - a * d));
    m.m02 = to_fix(2 * (b * d + a * c));
    m.m10 = to_fix(2 * (b * c + a * d));
    m.m11 = to_fix(1 - 2 * (b * b + d * d));
    m.m12 = to_fix(2 * (c * d - a * b));
    m.m20 = to_fix(2 * (b * d - a * c));
    m.m21 = to_fix(2 * (c * d + a * b));
    m.m22 = to_fix(1 - 2 * (b * b + c * c));
    return m;
  endfunction

  // Mostly real rotations; the rest raw bits or rotations with a few perturbed terms.
  task automatic queue_random(int n);
    matrix_t m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: m = matrix_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        2: begin
          m = rotation_matrix();
          m.m01 = 16'($urandom); m.m12 = 16'($urandom); m.m20 = 16'($urandom);
        end
        default: m = rotation_matrix();
      endcase
      matrix_q.push_back(m);
    end
  endtask

  // Check twice so an item popped in the same step as the check is still seen.
  task automatic wait_idle();
    repeat (2) begin
      while (matrix_q.size() > 0 || in_valid || quat_q.size() > 0) @(posedge clk);
      @(posedge clk);
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_floor(logic [14:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    floor_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_matrix(logic signed [15:0] d0, d1, d2, o01, o02, o10, o12, o20, o21);
    matrix_q.push_back('{d0, o01, o02, o10, d1, o12, o20, o21, d2});
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_wdata = '0;
    in_valid = 1'b0; out_ready = 1'b0; cur = '0;
    {in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22} = '0;
    floor_cfg = rmq_pkg::FLOOR_RESET; calm = 1'b0; hold_req = 1'b0;
    errors = 0; n_in = 0; n_out = 0; n_degen = 0; n_sat = 0; cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    write_floor(rmq_pkg::FLOOR_RESET);

    // Directed: identity, half-turns, trace at minus one, zero matrix,
    // extremes of the field range, saturation of w and of the vector parts.
    queue_matrix(16384, 16384, 16384, 0, 0, 0, 0, 0, 0);
    queue_matrix(16384, -16384, -16384, 0, 0, 0, 0, 0, 0);
    queue_matrix(-16384, -16384, -16384, 0, 0, 0, 0, 0, 0);
    queue_matrix(-16384, -16384, 16384, 0, 0, 0, 0, 0, 0);
    queue_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_matrix(0, 0, 0, -16384, 16384, 16384, 16384, -16384, 16384);
    queue_matrix(32767, 32767, 32767, -32768, 32767, 32767, -32768, -32768, 32767);
    queue_matrix(-32768, -32768, -32768, 32767, -32768, -32768, 32767, 32767, -32768);
    queue_matrix(-16384, -16384, -16370, -32768, 32767, 32767, -32768, 32767, -32768);
    queue_matrix(-16384, -16384, -16369, 32767, -32768, -32768, 32767, -32768, 32767);
    queue_matrix(-16384, -16384, 16, 100, -100, -100, 100, 100, -100);
    queue_matrix(-16384, -16384, 15, 100, -100, -100, 100, 100, -100);
    queue_matrix(-16384, -16384, 17, 1, -1, 1, -1, 1, -1);
    queue_matrix(-1, -1, -1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    queue_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 0);
    queue_matrix(0, 0, -16384, 0, 16384, 0, 0, 0, 0);
    wait_idle();

    // Floor at zero; the receiver takes one long pause mid-phase.
    write_floor(15'd0);
    queue_random(60);
    queue_matrix(-16384, -16384, -16384, 0, 0, 0, 0, 0, 0);
    queue_random(60);
    repeat (50) @(posedge clk);
    hold_req = 1'b1;
    wait_idle();

    // Floor at one, then others; each phase drains first.
    write_floor(15'd16384);
    queue_random(120);
    wait_idle();
    write_floor(15'd32767);
    queue_random(40);
    wait_idle();
    write_floor(15'($urandom_range(1, 16383)));
    queue_random(120);
    wait_idle();
    write_floor(15'd4000);
    queue_random(100);
    wait_idle();

    // Last stretch back at the reset floor, streaming with no idling.
    write_floor(rmq_pkg::FLOOR_RESET);
    calm = 1'b1;
    queue_random(130);
    wait_idle();

    $display("Ran %0d matrices through floors 0..32767, %0d results checked,", n_in, n_out);
    $display("%0d degenerate and %0d saturated, %0d mismatches.", n_degen, n_sat, errors);
    if (errors == 0 && quat_q.size() == 0 && n_out == n_in) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
